### design/md5ue_pkg.sv
// md5ue_pkg: shared types, constants and round functions of the md5 update engine
// no dependencies; used by md5ue_core, by the top level and by its checker
`default_nettype none

package md5ue_pkg;

  // standard md5 initial chaining value
  localparam logic [31:0] IV_WORD0 = 32'h67452301;
  localparam logic [31:0] IV_WORD1 = 32'hEFCDAB89;
  localparam logic [31:0] IV_WORD2 = 32'h98BADCFE;
  localparam logic [31:0] IV_WORD3 = 32'h10325476;

  // buffer position of the last byte of a block
  localparam logic [5:0] POS_LAST   = 6'h3f;
  localparam logic [5:0] ROUND_LAST = 6'd63;

  typedef logic [3:0][31:0] chain_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_e;

  // control from the sequencer to the round datapath
  typedef struct packed {
    logic       load_iv;
    logic       init;
    logic       step;
    logic       fold;
    logic [5:0] rnd;
  } md5ue_ctrl_t;

  localparam logic [31:0] K_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TABLE [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [31:0] md5_k(input logic [5:0] rnd);
    return K_TABLE[rnd];
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] rnd);
    return ROT_TABLE[{rnd[5:4], rnd[1:0]}];
  endfunction

  // message word index of a round
  function automatic logic [3:0] md5_g(input logic [5:0] rnd);
    logic [3:0] r;
    logic [3:0] g;
    r = rnd[3:0];
    case (rnd[5:4])
      2'd0:    g = r;
      2'd1:    g = 4'((r << 2) + r + 4'd1);
      2'd2:    g = 4'((r << 1) + r + 4'd5);
      2'd3:    g = 4'((r << 3) - r);
      default: g = r;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

### design/md5ue_buffer.sv
// md5ue_buffer: 64-byte block buffer, byte-wide write port, word-wide registered read port
// depends on nothing but the clock
`default_nettype none

module md5ue_buffer (
  input  logic        clk_i,
  input  logic        wr_en_i,
  input  logic [5:0]  wr_addr_i,
  input  logic [7:0]  wr_data_i,
  input  logic [3:0]  rd_addr_i,
  output logic [31:0] rd_data_o
);

  logic [31:0] mem [16];
  logic [31:0] rd_data_q;

  // byte write into the lane given by the low address bits
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i[5:2]][{wr_addr_i[1:0], 3'b000} +: 8] <= wr_data_i;
    end
  end

  // registered read, little-endian word
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### design/md5ue_core.sv
// md5ue_core: chaining words and the one-round-per-cycle md5 datapath
// depends on md5ue_pkg; message words come from md5ue_buffer
`default_nettype none

module md5ue_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  md5ue_pkg::md5ue_ctrl_t ctrl_i,
  input  logic [31:0]           msg_word_i,
  output md5ue_pkg::chain_t     chain_o
);
  import md5ue_pkg::*;

  chain_t      chain_q;
  logic [31:0] a_q, b_q, c_q, d_q;
  // a plus round constant, prepared one round ahead
  logic [31:0] pre_q;
  logic [31:0] f;
  logic [31:0] t;
  logic [63:0] t_rot;
  logic [31:0] b_next;

  // round function of the current phase
  always_comb begin
    case (ctrl_i.rnd[5:4])
      2'd0:    f = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f = (b_q & d_q) | (c_q & ~d_q);
      2'd2:    f = b_q ^ c_q ^ d_q;
      2'd3:    f = c_q ^ (b_q | ~d_q);
      default: f = b_q ^ c_q ^ d_q;
    endcase
  end

  assign t      = pre_q + f + msg_word_i;
  assign t_rot  = {t, t} << md5_rot(ctrl_i.rnd);
  assign b_next = b_q + t_rot[63:32];

  // working variables
  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      a_q   <= chain_q[0];
      b_q   <= chain_q[1];
      c_q   <= chain_q[2];
      d_q   <= chain_q[3];
      pre_q <= chain_q[0] + md5_k(6'd0);
    end else if (ctrl_i.step) begin
      a_q   <= d_q;
      b_q   <= b_next;
      c_q   <= b_q;
      d_q   <= c_q;
      pre_q <= d_q + md5_k(ctrl_i.rnd + 6'd1);
    end
  end

  // chaining words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= {IV_WORD3, IV_WORD2, IV_WORD1, IV_WORD0};
    end else if (ctrl_i.load_iv) begin
      chain_q <= {IV_WORD3, IV_WORD2, IV_WORD1, IV_WORD0};
    end else if (ctrl_i.fold) begin
      chain_q[0] <= chain_q[0] + a_q;
      chain_q[1] <= chain_q[1] + b_q;
      chain_q[2] <= chain_q[2] + c_q;
      chain_q[3] <= chain_q[3] + d_q;
    end
  end

  assign chain_o = chain_q;

endmodule

`default_nettype wire

### design/md5_update_engine.sv
// md5_update_engine: top level, byte intake, bit count, round sequencer and result register
// depends on md5ue_pkg, md5ue_buffer and md5ue_core
`default_nettype none

// Byte-serial MD5 update engine. One message byte is taken per cycle while
// a block fills and the output register is free. The byte that completes a
// 64-byte block starts the compression, during which no byte is taken: a
// load state primes the buffer read, 64 rounds follow at one per cycle, and
// a fold state adds the result into the chaining words. The round loop is
// fed one message word per cycle from the block buffer memory.
// A byte with end_of_update_i set gives one transaction on the output
// channel holding the chaining value and the bit count after that byte;
// if that byte completes a block, the result follows the compression. A
// new byte is taken while a result is waiting only if the output register
// is freed in the same cycle. No clearing pass follows reset.
module md5_update_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  message_byte_i,
  input  logic        start_message_i,
  input  logic        end_of_update_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_low_o,
  output logic [63:0] digest_high_o,
  output logic [63:0] bits_hashed_o
);
  import md5ue_pkg::*;

  state_e      state_q, state_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [63:0] count_q, count_d;
  logic        end_pend_q, end_pend_d;
  logic        out_valid_q;
  logic [63:0] dig_low_q, dig_high_q, bits_q;

  md5ue_ctrl_t ctrl;
  chain_t      chain;
  chain_t      dig_src;
  logic [31:0] msg_word;
  logic [5:0]  pos;
  logic [5:0]  rd_rnd;
  logic        accept;
  logic        out_free;
  logic        out_load;

  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;
  assign pos      = start_message_i ? 6'd0 : count_q[8:3];

  // sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    count_d     = count_q;
    end_pend_d  = end_pend_q;
    in_ready_o  = 1'b0;
    out_load    = 1'b0;
    ctrl        = '0;
    ctrl.rnd    = rnd_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          ctrl.load_iv = start_message_i;
          count_d      = (start_message_i ? 64'd0 : count_q) + 64'd8;
          if (pos == POS_LAST) begin
            end_pend_d = end_of_update_i;
            state_d    = ST_LOAD;
          end else begin
            out_load = end_of_update_i;
          end
        end
      end
      ST_LOAD: begin
        ctrl.init = 1'b1;
        rnd_d     = 6'd0;
        state_d   = ST_ROUND;
      end
      ST_ROUND: begin
        ctrl.step = 1'b1;
        rnd_d     = rnd_q + 6'd1;
        if (rnd_q == ROUND_LAST) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        ctrl.fold = 1'b1;
        state_d   = end_pend_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rnd_q      <= '0;
      count_q    <= '0;
      end_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rnd_q      <= rnd_d;
      count_q    <= count_d;
      end_pend_q <= end_pend_d;
    end
  end

  // read the message word one round ahead of its use
  assign rd_rnd = (state_q == ST_LOAD) ? 6'd0 : rnd_q + 6'd1;

  md5ue_buffer u_buffer (
    .clk_i     (clk_i),
    .wr_en_i   (accept),
    .wr_addr_i (pos),
    .wr_data_i (message_byte_i),
    .rd_addr_i (md5_g(rd_rnd)),
    .rd_data_o (msg_word)
  );

  md5ue_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .msg_word_i (msg_word),
    .chain_o    (chain)
  );

  // digest source: a start byte reports the reloaded initial value
  assign dig_src = (accept && start_message_i) ?
                   {IV_WORD3, IV_WORD2, IV_WORD1, IV_WORD0} : chain;

  // result register, valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register, payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      dig_low_q  <= {dig_src[1], dig_src[0]};
      dig_high_q <= {dig_src[3], dig_src[2]};
      bits_q     <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign digest_low_o  = dig_low_q;
  assign digest_high_o = dig_high_q;
  assign bits_hashed_o = bits_q;

endmodule

`default_nettype wire

### design/md5ue_checker.sv
// md5ue_checker: port-level assertions for md5_update_engine, bound to the top level
// depends on md5ue_pkg and md5_update_engine
`default_nettype none

module md5ue_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic        start_message_i,
  input  logic        end_of_update_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [63:0] digest_low_o,
  input  logic [63:0] bits_hashed_o
);
  import md5ue_pkg::*;

  // a stalled result transaction holds its low digest words and bit count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(digest_low_o)
      && $stable(bits_hashed_o))
    else $error("stalled result changed");

  // no byte is taken while a result waits and is not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("byte taken over a blocked result");

  // the count only ever advances in whole bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bits_hashed_o[2:0] == 3'd0)
    else $error("bit count not byte aligned");

  // a one-byte message reports the low initial value words and eight bits next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && start_message_i && end_of_update_i |=>
      out_valid_o && bits_hashed_o == 64'd8
      && digest_low_o == {IV_WORD1, IV_WORD0})
    else $error("one-byte message result wrong");

endmodule

bind md5_update_engine md5ue_checker u_md5ue_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .start_message_i (start_message_i),
  .end_of_update_i (end_of_update_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .digest_low_o    (digest_low_o),
  .bits_hashed_o   (bits_hashed_o)
);

`default_nettype wire
